@@ rtl/hce_pkg.sv @@
// Shared types, constants and the modulo-26 reduction for the Hill cipher encryptor.
`default_nettype none
package hce_pkg;
   localparam int unsigned LetterW    = 5;
   localparam int unsigned RowW       = 15;
   localparam int unsigned AccW       = 12;
   localparam int unsigned Alphabet   = 26;
   localparam int unsigned Recip      = 2521;
   localparam int unsigned RecipShift = 16;
   localparam int unsigned ProdW      = AccW + 12;

   typedef logic [LetterW-1:0] letter_type;

   typedef enum logic [1:0] {
      REG_ORDER = 2'd0,
      REG_ROW0  = 2'd1,
      REG_ROW1  = 2'd2,
      REG_ROW2  = 2'd3
   } reg_type;

   typedef struct packed {
      letter_type [2:0] vec;
      logic             size3;
      logic             last;
   } blk_type;

   typedef struct packed {
      logic                 order;
      logic [2:0][RowW-1:0] rows;
   } key_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // x <= 2883: reciprocal quotient is exact, final compare kept as a guard
   function automatic letter_type mod26(input logic [AccW-1:0] x);
      logic [ProdW-1:0] prod;
      logic [AccW-1:0]  q;
      logic [AccW-1:0]  r;
      prod = {{(ProdW-AccW){1'b0}}, x} * ProdW'(Recip);
      q    = AccW'(prod >> RecipShift);
      r    = x - AccW'(q * AccW'(Alphabet));
      if (r >= AccW'(Alphabet)) begin
         r = r - AccW'(Alphabet);
      end
      return r[LetterW-1:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/hill_cipher_encrypt.sv @@
// Top level of the streaming Hill cipher encryptor with its register port.
// Takes one plaintext letter per cycle while the two-entry block queue has room; a letter
// that completes a block (2 or 3 letters, or any letter marked message_end, padded with 'a')
// queues it. The back end emits one cipher letter per key row, one per cycle while rsp_stall
// is low, so a block of n letters yields n results, each through the queue register, the
// dot-product stage and the modulo-26 output register. Sustained rate is one letter per
// cycle while the output is not stalled; short final blocks produce more results than
// letters and may stall the input briefly. Registers: key_order at 0x0, key rows 0..2 at
// 0x4, 0x8, 0xC.
`default_nettype none
module hill_cipher_encrypt (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire hce_pkg::letter_type req_plain_letter,
   input  wire logic                req_message_end,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output hce_pkg::letter_type      rsp_cipher_letter,
   output logic                     rsp_final_output,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [3:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   hce_pkg::key_type   key_ff;
   hce_pkg::blk_type   push_blk, head;
   hce_pkg::qstat_type q_stat;
   hce_pkg::reg_type   reg_sel;
   logic               push, pop, row_busy, csr_wr;

   assign csr_pready = 1'b1;
   assign reg_sel    = hce_pkg::reg_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.order <= 1'b1;
         key_ff.rows  <= '0;
      end else if (csr_wr) begin
         case (reg_sel)
            hce_pkg::REG_ORDER: key_ff.order   <= csr_pwdata[0];
            hce_pkg::REG_ROW0:  key_ff.rows[0] <= csr_pwdata[hce_pkg::RowW-1:0];
            hce_pkg::REG_ROW1:  key_ff.rows[1] <= csr_pwdata[hce_pkg::RowW-1:0];
            hce_pkg::REG_ROW2:  key_ff.rows[2] <= csr_pwdata[hce_pkg::RowW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         hce_pkg::REG_ORDER: csr_prdata = {31'd0, key_ff.order};
         hce_pkg::REG_ROW0:  csr_prdata = {17'd0, key_ff.rows[0]};
         hce_pkg::REG_ROW1:  csr_prdata = {17'd0, key_ff.rows[1]};
         hce_pkg::REG_ROW2:  csr_prdata = {17'd0, key_ff.rows[2]};
         default:            csr_prdata = '0;
      endcase
   end

   hce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_plain_letter (req_plain_letter),
      .req_message_end  (req_message_end),
      .key_order        (key_ff.order),
      .q_stat           (q_stat),
      .push             (push),
      .push_blk         (push_blk)
   );

   hce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_blk (push_blk),
      .pop      (pop),
      .head     (head),
      .stat     (q_stat)
   );

   hce_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_stat            (q_stat),
      .key_rows          (key_ff.rows),
      .pop               (pop),
      .row_busy          (row_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cipher_letter (rsp_cipher_letter),
      .rsp_final_output  (rsp_final_output)
   );

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_stat.empty)
      else $error("completed block did not reach the queue");

   a_row_has_block: assert property (@(posedge clock) disable iff (reset)
      row_busy |-> !q_stat.empty)
      else $error("row counter mid-block with an empty queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("block popped from an empty queue");

   a_cipher_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cipher_letter < hce_pkg::letter_type'(hce_pkg::Alphabet)))
      else $error("cipher letter not reduced modulo 26");
endmodule
`default_nettype wire

@@ rtl/hce_front.sv @@
// Front end: takes letters, gathers them into blocks and hands full blocks to the queue.
`default_nettype none
module hce_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire hce_pkg::letter_type req_plain_letter,
   input  wire logic               req_message_end,
   input  wire logic               key_order,
   input  wire hce_pkg::qstat_type q_stat,
   output logic                    push,
   output hce_pkg::blk_type        push_blk
);
   logic [1:0]          fill_ff, fill_in;
   hce_pkg::letter_type buf_ff [2];
   logic                accept, complete;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign complete  = req_message_end || (key_order ? (fill_ff >= 2'd2) : (fill_ff >= 2'd1));
   assign push      = accept && complete;

   always_comb begin
      push_blk.size3 = key_order;
      push_blk.last  = req_message_end;
      push_blk.vec   = '0;
      case (fill_ff)
         2'd0: begin
            push_blk.vec[0] = req_plain_letter;
         end
         2'd1: begin
            push_blk.vec[0] = buf_ff[0];
            push_blk.vec[1] = req_plain_letter;
         end
         default: begin
            push_blk.vec[0] = buf_ff[0];
            if (key_order) begin
               push_blk.vec[1] = buf_ff[1];
               push_blk.vec[2] = req_plain_letter;
            end else begin
               push_blk.vec[1] = req_plain_letter;
            end
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = complete ? 2'd0 : fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !complete) begin
         buf_ff[fill_ff[0]] <= req_plain_letter;
      end
   end
endmodule
`default_nettype wire

@@ rtl/hce_queue.sv @@
// Two-entry block queue between front end and product pipe.
`default_nettype none
module hce_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire hce_pkg::blk_type push_blk,
   input  wire logic             pop,
   output hce_pkg::blk_type      head,
   output hce_pkg::qstat_type    stat
);
   hce_pkg::blk_type mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign stat.empty = (cnt_ff == 2'd0);
   assign stat.full  = (cnt_ff == 2'd2);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_blk;
      end
   end
endmodule
`default_nettype wire

@@ rtl/hce_back.sv @@
// Back end: one key row per cycle when not stalled; dot product, modulo-26 into output register.
`default_nettype none
module hce_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hce_pkg::blk_type           head,
   input  wire hce_pkg::qstat_type         q_stat,
   input  wire logic [2:0][hce_pkg::RowW-1:0] key_rows,
   output logic                            pop,
   output logic                            row_busy,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output hce_pkg::letter_type             rsp_cipher_letter,
   output logic                            rsp_final_output
);
   logic [1:0]                row_ff, row_in, last_row;
   logic                      en, take;
   logic [hce_pkg::AccW-1:0]  acc_ff, acc_in;
   logic                      va_ff, fin_ff;
   logic                      rsp_valid_ff;
   hce_pkg::letter_type       rsp_letter_ff;
   logic                      rsp_final_ff;
   logic [hce_pkg::RowW-1:0]  key_row;

   assign en       = !rsp_valid_ff || !rsp_stall;
   assign take     = en && !q_stat.empty;
   assign last_row = head.size3 ? 2'd2 : 2'd1;
   assign pop      = take && (row_ff == last_row);
   assign row_busy = (row_ff != 2'd0);
   assign key_row  = key_rows[row_ff];

   always_comb begin
      acc_in = '0;
      for (int c = 0; c < 3; c++) begin
         acc_in = acc_in
                + hce_pkg::AccW'(key_row[c*hce_pkg::LetterW +: hce_pkg::LetterW])
                * hce_pkg::AccW'(head.vec[c]);
      end
   end

   always_comb begin
      row_in = row_ff;
      if (take) begin
         row_in = (row_ff == last_row) ? 2'd0 : row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 2'd0;
         va_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         if (en) begin
            va_ff        <= !q_stat.empty;
            rsp_valid_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff        <= acc_in;
         fin_ff        <= head.last && (row_ff == last_row);
         rsp_letter_ff <= hce_pkg::mod26(acc_ff);
         rsp_final_ff  <= fin_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cipher_letter = rsp_letter_ff;
   assign rsp_final_output  = rsp_final_ff;
endmodule
`default_nettype wire

@@ tb/hill_cipher_encrypt_tb.sv @@
// Self-checking testbench for the streaming Hill cipher encryptor.
`timescale 1ns / 100ps
module hill_cipher_encrypt_tb;

   typedef struct {
      hce_pkg::letter_type cipher;
      logic                final_flag;
   } cipher_item_type;

   class cipher_scoreboard_type;
      logic                order_3x3;
      logic [14:0]         key_rows [3];
      hce_pkg::letter_type held [2];
      int unsigned         held_count;
      cipher_item_type     pending [$];
      int unsigned         mismatches;

      function new();
         order_3x3  = 1'b1;
         key_rows   = '{default: '0};
         held       = '{default: '0};
         held_count = 0;
         mismatches = 0;
      endfunction

      function void set_register(hce_pkg::reg_type idx, logic [31:0] value);
         case (idx)
            hce_pkg::REG_ORDER: order_3x3 = value[0];
            hce_pkg::REG_ROW0: key_rows[0] = value[14:0];
            hce_pkg::REG_ROW1: key_rows[1] = value[14:0];
            hce_pkg::REG_ROW2: key_rows[2] = value[14:0];
            default: ;
         endcase
      endfunction

      // Gathers a letter into the current block and enciphers the block once it is complete.
      function void note_plain(hce_pkg::letter_type letter, logic msg_end);
         int unsigned     size;
         int unsigned     pos;
         int unsigned     acc;
         int unsigned     vec [3];
         cipher_item_type item;
         size = order_3x3 ? 3 : 2;
         pos  = held_count;
         if (pos < size - 1 && !msg_end) begin
            held[pos % 2] = letter;
            held_count = (pos + 1) % 4;
            return;
         end
         if (pos > size - 1) begin
            pos = size - 1;
         end
         vec = '{default: 0};
         for (int c = 0; c < pos; c++) begin
            vec[c] = held[c % 2];
         end
         vec[pos] = letter;
         for (int r = 0; r < size; r++) begin
            acc = 0;
            for (int c = 0; c < size; c++) begin
               acc += key_rows[r][5*c +: 5] * vec[c];
            end
            item.cipher     = hce_pkg::letter_type'(acc % hce_pkg::Alphabet);
            item.final_flag = msg_end && (r == size - 1);
            pending = {pending, item};
         end
         held_count = 0;
         held       = '{default: '0};
      endfunction

      function void check_cipher(hce_pkg::letter_type got, logic got_final);
         cipher_item_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected cipher transaction: expected none, actual letter %0d final %0b",
                     $time, got, got_final);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (got !== want.cipher) begin
            $display("%0t: cipher_letter mismatch: expected %0d, actual %0d",
                     $time, want.cipher, got);
            mismatches++;
         end
         if (got_final !== want.final_flag) begin
            $display("%0t: final_output mismatch: expected %0b, actual %0b",
                     $time, want.final_flag, got_final);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return pending.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   hce_pkg::letter_type req_plain_letter = '0;
   logic                req_message_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   hce_pkg::letter_type rsp_cipher_letter;
   logic                rsp_final_output;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [3:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   cipher_scoreboard_type sb = new();

   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;
   bit          hold_off_request = 1'b0;
   int unsigned hold_left = 0;
   int unsigned idle_cycles = 0;

   localparam int unsigned WatchdogLimit = 1000;
   localparam int unsigned LongHold      = 150;

   hill_cipher_encrypt dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_plain_letter  (req_plain_letter),
      .req_message_end   (req_message_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cipher_letter (rsp_cipher_letter),
      .rsp_final_output  (rsp_final_output),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #1 clock = ~clock;

   // receiving side: check, then choose the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_cipher(rsp_cipher_letter, rsp_final_output);
      end
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left = LongHold;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(0, 15);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_letter(hce_pkg::letter_type letter, logic msg_end);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_plain_letter <= letter;
      req_message_end  <= msg_end;
      do @(posedge clock); while (req_stall);
      sb.note_plain(letter, msg_end);
   endtask

   // written only once every pending cipher letter has drained
   task automatic csr_write(hce_pkg::reg_type idx, logic [31:0] value);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_register(idx, value);
   endtask

   function automatic logic [31:0] random_row();
      if ($urandom_range(0, 4) == 0) begin
         return $urandom_range(0, 32767);
      end
      return {17'd0, 5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
              5'($urandom_range(0, 25))};
   endfunction

   function automatic hce_pkg::letter_type random_letter();
      if ($urandom_range(0, 9) == 0) begin
         return hce_pkg::letter_type'($urandom_range(26, 31));
      end
      return hce_pkg::letter_type'($urandom_range(0, 25));
   endfunction

   initial begin
      int unsigned sent;
      int unsigned msg_len;
      logic        with_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset key: all zero, 3x3, single padded letter
      send_letter(5'd7, 1'b1);

      csr_write(hce_pkg::REG_ROW0, 32'h6739);
      csr_write(hce_pkg::REG_ROW1, 32'h6739);
      csr_write(hce_pkg::REG_ROW2, 32'h6739);
      send_letter(5'd25, 1'b0);
      send_letter(5'd25, 1'b0);
      send_letter(5'd25, 1'b1);
      send_letter(5'd0, 1'b0);
      send_letter(5'd0, 1'b0);
      send_letter(5'd0, 1'b0);

      // raw 5-bit key entries and letters above z
      csr_write(hce_pkg::REG_ROW0, 32'h7FFF);
      csr_write(hce_pkg::REG_ROW1, 32'h7FFF);
      csr_write(hce_pkg::REG_ROW2, 32'h7FFF);
      send_letter(5'd31, 1'b0);
      send_letter(5'd31, 1'b0);
      send_letter(5'd31, 1'b0);
      send_letter(5'd30, 1'b1);
      send_letter(5'd4, 1'b0);
      send_letter(5'd17, 1'b1);

      csr_write(hce_pkg::REG_ORDER, 32'd0);
      csr_write(hce_pkg::REG_ROW0, {17'd0, 5'd0, 5'd3, 5'd3});
      csr_write(hce_pkg::REG_ROW1, {17'd0, 5'd0, 5'd5, 5'd2});
      send_letter(5'd7, 1'b0);
      send_letter(5'd4, 1'b0);
      send_letter(5'd11, 1'b1);
      send_letter(5'd1, 1'b0);
      send_letter(5'd2, 1'b1);

      // order changed with a partial block held
      csr_write(hce_pkg::REG_ORDER, 32'd1);
      csr_write(hce_pkg::REG_ROW2, {17'd0, 5'd9, 5'd14, 5'd21});
      send_letter(5'd5, 1'b0);
      send_letter(5'd9, 1'b0);
      csr_write(hce_pkg::REG_ORDER, 32'd0);
      send_letter(5'd13, 1'b0);
      send_letter(5'd6, 1'b0);
      csr_write(hce_pkg::REG_ORDER, 32'd1);
      send_letter(5'd8, 1'b0);
      send_letter(5'd10, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase >= 6) begin
            sender_gaps   = 1'b0;
            receiver_gaps = 1'b0;
         end
         csr_write(hce_pkg::REG_ORDER, (phase < 2) ? phase : $urandom_range(0, 1));
         csr_write(hce_pkg::REG_ROW0, random_row());
         csr_write(hce_pkg::REG_ROW1, random_row());
         csr_write(hce_pkg::REG_ROW2, random_row());
         if (phase == 3) begin
            sender_gaps      = 1'b0;
            hold_off_request = 1'b1;
         end
         sent = 0;
         while (sent < ((phase == 3) ? 14 : 8)) begin
            msg_len  = $urandom_range(1, 7);
            with_end = ($urandom_range(0, 7) != 0);
            for (int i = 0; i < msg_len; i++) begin
               send_letter(random_letter(), with_end && (i == msg_len - 1));
            end
            sent += msg_len;
         end
         if (phase == 3) begin
            sender_gaps = 1'b1;
         end
      end

      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
